FILE: hdl/srpc_pkg.sv
// Shared types, codes and constants for the session run/pause controller.
// No dependencies; imported by session_run_pause_controller_top and tb_top.
`default_nettype none

package srpc_pkg;

	localparam int unsigned VALUE_MAX        = 1000;
	localparam int unsigned PRESSURE_DEFAULT = 250;
	localparam int unsigned MODE_MAX         = 4;

	localparam int unsigned CFG_ADDR_W = 5;
	localparam int unsigned CFG_DATA_W = 32;

	// Register indexes of the configuration port (byte address = 4 * index)
	localparam logic [2:0] REG_TEMP_COMP   = 3'd0;
	localparam logic [2:0] REG_BOOT_MODE   = 3'd1;
	localparam logic [2:0] REG_BOOT_TEMP   = 3'd2;
	localparam logic [2:0] REG_SLOT0_PRESS = 3'd3;
	localparam logic [2:0] REG_SLOT1_PRESS = 3'd4;
	localparam logic [2:0] REG_CYCLE_TICKS = 3'd5;
	localparam logic [2:0] REG_SAVE_DELAY  = 3'd6;

	// Register reset values
	localparam logic [9:0]  RST_TEMP_COMP   = 10'd0;
	localparam logic [7:0]  RST_BOOT_MODE   = 8'd1;
	localparam logic [9:0]  RST_BOOT_TEMP   = 10'd400;
	localparam logic [9:0]  RST_SLOT_PRESS  = 10'd250;
	localparam logic [15:0] RST_CYCLE_TICKS = 16'd60000;
	localparam logic [15:0] RST_SAVE_DELAY  = 16'd3000;

	typedef enum logic [3:0] {
		OP_INIT   = 4'd0,
		OP_TICK   = 4'd1,
		OP_MODE   = 4'd2,
		OP_TEMP   = 4'd3,
		OP_PRESS  = 4'd4,
		OP_LEFT   = 4'd5,
		OP_RIGHT  = 4'd6,
		OP_CYCLES = 4'd7,
		OP_START  = 4'd8,
		OP_STOP   = 4'd9,
		OP_PAUSE  = 4'd10,
		OP_READ   = 4'd11,
		OP_SAVE   = 4'd12,
		OP_FAULT  = 4'd13
	} op_t;

	typedef enum logic [2:0] {
		CMD_NONE   = 3'd0,
		CMD_START  = 3'd1,
		CMD_STOP   = 3'd2,
		CMD_PAUSE  = 3'd3,
		CMD_RESUME = 3'd4,
		CMD_UPDATE = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_READY = 2'd1,
		PH_RUN   = 2'd2,
		PH_ALARM = 2'd3
	} phase_t;

	typedef struct packed {
		cmd_t        command;
		logic        running;
		logic [2:0]  mode;
		logic [9:0]  temperature;
		logic [9:0]  pressure;
		logic [1:0]  enables;
		logic [15:0] cycles;
		logic        save;
		logic        broadcast;
		logic        done;
		phase_t      phase;
		logic        treating;
	} result_t;

	// Saturate a tenths value to the 0..1000 range
	function automatic logic [9:0] clamp_value(input logic [15:0] v);
		logic [9:0] r;
		if (v > 16'(VALUE_MAX)) begin
			r = 10'(VALUE_MAX);
		end else begin
			r = v[9:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/session_run_pause_controller_top.sv
// Top level of the session run/pause controller: event register, single-pass
// event logic, result register and APB-style configuration registers. Uses srpc_pkg.
`default_nettype none

// Session run/pause controller. Each request on the event channel (operation,
// value) is one host command, safety fault or time tick, and yields exactly one
// result: the control command it caused with the packed settings, the save,
// broadcast and session-done flags, the application phase and the treatment
// flag. The block takes one request every clock cycle while the result side is
// not stalled and returns results in order; a request is registered in the
// event register at acceptance and its result in the result register. The rate
// is set by the single-pass event logic, whose longest path is the 16x16 multiply
// of cycle ticks by session cycles feeding the session deadline add. A stalled result
// holds in the result register while one further request waits in the event
// register. Configuration registers sit at byte addresses 4*index and are to be
// written only while the controller is idle.
module session_run_pause_controller_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// event channel
	input  wire logic        evt_valid,
	output logic             evt_stall,
	input  wire logic [3:0]  operation,
	input  wire logic [15:0] value,
	// result channel
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [2:0]       ctrl_command,
	output logic             ctrl_running,
	output logic [2:0]       ctrl_mode,
	output logic [9:0]       ctrl_temperature,
	output logic [9:0]       ctrl_pressure,
	output logic [1:0]       ctrl_enables,
	output logic [15:0]      ctrl_cycles,
	output logic             save_request,
	output logic             broadcast_request,
	output logic             session_done,
	output logic [1:0]       app_status,
	output logic             treatment_on,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [srpc_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [srpc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [srpc_pkg::CFG_DATA_W-1:0]      prdata,
	output logic             pready
);
	import srpc_pkg::*;

	// ---------------------------------------------------------------- config
	logic [9:0]  temp_comp_q;
	logic [7:0]  boot_mode_q;
	logic [9:0]  boot_temp_q;
	logic [9:0]  slot0_init_q;
	logic [9:0]  slot1_init_q;
	logic [15:0] cycle_ticks_q;
	logic [15:0] save_delay_q;
	logic        cfg_wr;
	logic [2:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[CFG_ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_comp_q   <= RST_TEMP_COMP;
			boot_mode_q   <= RST_BOOT_MODE;
			boot_temp_q   <= RST_BOOT_TEMP;
			slot0_init_q  <= RST_SLOT_PRESS;
			slot1_init_q  <= RST_SLOT_PRESS;
			cycle_ticks_q <= RST_CYCLE_TICKS;
			save_delay_q  <= RST_SAVE_DELAY;
		end else if (cfg_wr) begin
			// addresses beyond the register list are dropped
			unique case (cfg_idx)
				REG_TEMP_COMP:   temp_comp_q   <= pwdata[9:0];
				REG_BOOT_MODE:   boot_mode_q   <= pwdata[7:0];
				REG_BOOT_TEMP:   boot_temp_q   <= pwdata[9:0];
				REG_SLOT0_PRESS: slot0_init_q  <= pwdata[9:0];
				REG_SLOT1_PRESS: slot1_init_q  <= pwdata[9:0];
				REG_CYCLE_TICKS: cycle_ticks_q <= pwdata[15:0];
				REG_SAVE_DELAY:  save_delay_q  <= pwdata[15:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_TEMP_COMP:   prdata = CFG_DATA_W'(temp_comp_q);
			REG_BOOT_MODE:   prdata = CFG_DATA_W'(boot_mode_q);
			REG_BOOT_TEMP:   prdata = CFG_DATA_W'(boot_temp_q);
			REG_SLOT0_PRESS: prdata = CFG_DATA_W'(slot0_init_q);
			REG_SLOT1_PRESS: prdata = CFG_DATA_W'(slot1_init_q);
			REG_CYCLE_TICKS: prdata = CFG_DATA_W'(cycle_ticks_q);
			REG_SAVE_DELAY:  prdata = CFG_DATA_W'(save_delay_q);
			default:         prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- handshake
	logic        evt_valid_s1;
	op_t         op_s1;
	logic [15:0] value_s1;
	logic        res_valid_s2;
	result_t     res_s2;
	logic        advance;

	// The event register moves on whenever the result register is empty or
	// being taken; otherwise hold the request and stall the sender.
	assign advance   = evt_valid_s1 && (!res_valid_s2 || !res_stall);
	assign evt_stall = evt_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s1 <= 1'b0;
		end else if (evt_valid && !evt_stall) begin
			evt_valid_s1 <= 1'b1;
		end else if (advance) begin
			evt_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && !evt_stall) begin
			op_s1    <= op_t'(operation);
			value_s1 <= value;
		end
	end

	// ---------------------------------------------------------------- state
	logic [31:0] now_q;
	logic [2:0]  mode_q;
	logic [9:0]  temp_q;
	logic [9:0]  press_q;
	logic [9:0]  slot0_q;
	logic [9:0]  slot1_q;
	logic [15:0] cycles_q;
	logic        req_run_q, req_pause_q, req_left_q, req_right_q;
	logic        active_q, paused_q, timer_q;
	logic [31:0] end_q;
	logic [31:0] rem_q;
	logic [31:0] save_dl_q;
	logic        save_pend_q;
	phase_t      phase_q;
	logic        treat_q;

	// next-state values
	logic [31:0] n_now;
	logic [2:0]  n_mode;
	logic [9:0]  n_temp;
	logic [9:0]  n_press;
	logic [9:0]  n_slot0;
	logic [9:0]  n_slot1;
	logic [15:0] n_cycles;
	logic        n_run, n_pause, n_left, n_right;
	logic        n_active, n_paused, n_timer;
	logic [31:0] n_end;
	logic [31:0] n_rem;
	logic [31:0] n_save_dl;
	logic        n_save_pend;
	phase_t      n_phase;
	logic        n_treat;

	// result bits
	cmd_t        r_cmd;
	logic        r_running;
	logic        r_posted;
	logic        r_save;
	logic        r_bcast;
	logic        r_done;
	logic        do_update;

	// Session length product: an arm uses the new cycle count on a cycles
	// request and the stored count otherwise.
	logic [15:0] arm_count;
	logic [31:0] arm_prod;
	assign arm_count = (op_s1 == OP_CYCLES) ? ((value_s1 == '0) ? 16'd1 : value_s1)
	                                        : cycles_q;
	assign arm_prod  = 32'(cycle_ticks_q) * 32'(arm_count);

	logic [31:0] now_inc;
	logic [31:0] save_dl_new;
	logic        save_due;
	logic        session_due;
	logic [9:0]  press_clamped;
	logic [2:0]  mode_from_value;
	logic [2:0]  mode_from_boot;
	logic [9:0]  slot_pick_value;
	logic [9:0]  slot_pick_boot;
	logic [9:0]  slot0_boot;
	logic [9:0]  slot1_boot;
	logic        run_cond;

	assign now_inc     = now_q + 32'd1;
	assign save_dl_new = now_q + 32'(save_delay_q);
	// deadline reached when (now - deadline) is not negative
	assign save_due    = save_pend_q && !((now_inc - save_dl_q) >> 31 != 32'd0);
	assign session_due = active_q && !paused_q && timer_q && !((now_inc - end_q) >> 31 != 32'd0);

	assign press_clamped   = clamp_value(value_s1);
	assign mode_from_value = (value_s1 == '0) ? 3'd1 :
	                         (value_s1 > 16'(MODE_MAX)) ? 3'(MODE_MAX) : value_s1[2:0];
	assign mode_from_boot  = (boot_mode_q >= 8'd1 && boot_mode_q <= 8'(MODE_MAX))
	                         ? boot_mode_q[2:0] : 3'd1;
	assign slot_pick_value = (mode_from_value <= 3'd1) ? slot0_q : slot1_q;
	assign slot0_boot      = clamp_value(16'(slot0_init_q));
	assign slot1_boot      = clamp_value(16'(slot1_init_q));
	assign slot_pick_boot  = (mode_from_boot <= 3'd1) ? slot0_boot : slot1_boot;

	always_comb begin
		n_now       = now_q;
		n_mode      = mode_q;
		n_temp      = temp_q;
		n_press     = press_q;
		n_slot0     = slot0_q;
		n_slot1     = slot1_q;
		n_cycles    = cycles_q;
		n_run       = req_run_q;
		n_pause     = req_pause_q;
		n_left      = req_left_q;
		n_right     = req_right_q;
		n_active    = active_q;
		n_paused    = paused_q;
		n_timer     = timer_q;
		n_end       = end_q;
		n_rem       = rem_q;
		n_save_dl   = save_dl_q;
		n_save_pend = save_pend_q;
		n_phase     = phase_q;
		n_treat     = treat_q;
		r_cmd       = CMD_NONE;
		r_running   = 1'b0;
		r_posted    = 1'b0;
		r_save      = 1'b0;
		r_bcast     = 1'b0;
		r_done      = 1'b0;
		do_update   = 1'b0;
		run_cond    = 1'b0;

		// request-specific work ahead of the run/pause update
		unique case (op_s1)
			OP_INIT: begin
				n_slot0     = slot0_boot;
				n_slot1     = slot1_boot;
				n_mode      = mode_from_boot;
				n_press     = (slot_pick_boot != '0) ? slot_pick_boot : 10'(PRESSURE_DEFAULT);
				n_temp      = clamp_value(16'(boot_temp_q));
				n_run       = 1'b0;
				n_pause     = 1'b0;
				n_left      = 1'b0;
				n_right     = 1'b0;
				n_active    = 1'b0;
				n_paused    = 1'b0;
				n_timer     = 1'b0;
				n_rem       = '0;
				n_save_pend = 1'b0;
				n_save_dl   = '0;
				n_phase     = PH_IDLE;
				r_posted    = 1'b1;
			end
			OP_TICK: begin
				n_now = now_inc;
				if (save_due) begin
					r_save      = 1'b1;
					n_save_pend = 1'b0;
					n_save_dl   = '0;
				end
				if (session_due) begin
					n_run     = 1'b0;
					n_pause   = 1'b0;
					n_timer   = 1'b0;
					n_rem     = '0;
					do_update = 1'b1;
					r_done    = 1'b1;
				end
			end
			OP_MODE: begin
				n_mode    = mode_from_value;
				n_press   = (slot_pick_value != '0) ? slot_pick_value : 10'(PRESSURE_DEFAULT);
				do_update = 1'b1;
			end
			OP_TEMP: begin
				n_temp      = press_clamped;
				n_save_dl   = save_dl_new;
				n_save_pend = 1'b1;
				do_update   = 1'b1;
			end
			OP_PRESS: begin
				n_press = press_clamped;
				if (mode_q <= 3'd1) begin
					n_slot0 = press_clamped;
				end else begin
					n_slot1 = press_clamped;
				end
				n_save_dl   = save_dl_new;
				n_save_pend = 1'b1;
				do_update   = 1'b1;
			end
			OP_LEFT: begin
				n_left    = (value_s1 != '0);
				do_update = 1'b1;
			end
			OP_RIGHT: begin
				n_right   = (value_s1 != '0);
				do_update = 1'b1;
			end
			OP_CYCLES: begin
				n_cycles = arm_count;
				if (active_q) begin
					n_end     = now_q + arm_prod;
					n_timer   = 1'b1;
					do_update = 1'b1;
				end
			end
			OP_START: begin
				if (!req_left_q && !req_right_q) begin
					n_left  = 1'b1;
					n_right = 1'b1;
				end
				n_pause   = 1'b0;
				n_run     = 1'b1;
				do_update = 1'b1;
			end
			OP_STOP: begin
				n_run     = 1'b0;
				n_pause   = 1'b0;
				do_update = 1'b1;
			end
			OP_PAUSE: begin
				if (value_s1 == '0) begin
					if (req_run_q && !req_pause_q) begin
						n_pause = 1'b1;
						// freeze the countdown
						if (timer_q && (end_q > now_q)) begin
							n_rem = end_q - now_q;
						end else begin
							n_rem = '0;
						end
						n_timer   = 1'b0;
						do_update = 1'b1;
					end
				end else if (req_run_q && req_pause_q) begin
					n_pause   = 1'b0;
					do_update = 1'b1;
				end
			end
			OP_READ:  r_bcast = 1'b1;
			OP_SAVE:  r_save  = 1'b1;
			OP_FAULT: begin
				if (value_s1 != '0) begin
					n_run     = 1'b0;
					n_pause   = 1'b0;
					n_left    = 1'b0;
					n_right   = 1'b0;
					do_update = 1'b1;
				end
			end
			default: ;
		endcase

		// run/pause update
		if (do_update) begin
			run_cond = n_run && (n_left || n_right);
			if (run_cond) begin
				if (n_pause) begin
					n_treat = 1'b0;
					n_phase = PH_READY;
					if (n_active && !n_paused) begin
						n_paused  = 1'b1;
						r_cmd     = CMD_PAUSE;
						r_running = 1'b1;
						r_posted  = 1'b1;
					end
				end else begin
					n_treat   = 1'b1;
					n_phase   = PH_RUN;
					r_running = 1'b1;
					r_posted  = 1'b1;
					if (!n_active) begin
						n_active = 1'b1;
						n_paused = 1'b0;
						r_cmd    = CMD_START;
						if (!n_timer) begin
							n_timer = 1'b1;
							n_end   = (n_rem != '0) ? n_now + n_rem : n_now + arm_prod;
						end
					end else if (n_paused) begin
						n_paused = 1'b0;
						r_cmd    = CMD_RESUME;
						if (!n_timer && (n_rem != '0)) begin
							n_timer = 1'b1;
							n_end   = n_now + n_rem;
						end
					end else begin
						r_cmd = CMD_UPDATE;
						if (!n_timer) begin
							n_timer = 1'b1;
							n_end   = n_now + arm_prod;
						end
					end
				end
			end else begin
				n_treat = 1'b0;
				if (n_active || n_paused) begin
					n_active  = 1'b0;
					n_paused  = 1'b0;
					r_cmd     = CMD_STOP;
					r_running = 1'b0;
					r_posted  = 1'b1;
				end
				n_phase = PH_READY;
				n_timer = 1'b0;
				n_rem   = '0;
			end
			// a fault leaves the alarm phase over whatever the update chose
			if (op_s1 == OP_FAULT) begin
				n_phase = PH_ALARM;
			end
		end
	end

	// Settings shown with the result: those in force when a command went out
	// (or after init), otherwise the settings held before the request.
	result_t     res_next;
	logic [9:0]  src_temp;
	always_comb begin
		src_temp             = r_posted ? n_temp : temp_q;
		res_next.command     = r_cmd;
		res_next.running     = r_running;
		res_next.mode        = r_posted ? n_mode : mode_q;
		res_next.temperature = (src_temp > temp_comp_q) ? src_temp - temp_comp_q : '0;
		res_next.pressure    = r_posted ? n_press : press_q;
		res_next.enables     = r_posted ? {n_right, n_left} : {req_right_q, req_left_q};
		res_next.cycles      = r_posted ? n_cycles : cycles_q;
		res_next.save        = r_save;
		res_next.broadcast   = r_bcast;
		res_next.done        = r_done;
		res_next.phase       = n_phase;
		res_next.treating    = n_treat;
	end

	// commit state as the request leaves the event register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			mode_q      <= 3'd1;
			temp_q      <= '0;
			press_q     <= 10'(PRESSURE_DEFAULT);
			slot0_q     <= 10'(PRESSURE_DEFAULT);
			slot1_q     <= 10'(PRESSURE_DEFAULT);
			cycles_q    <= 16'd1;
			req_run_q   <= 1'b0;
			req_pause_q <= 1'b0;
			req_left_q  <= 1'b0;
			req_right_q <= 1'b0;
			active_q    <= 1'b0;
			paused_q    <= 1'b0;
			timer_q     <= 1'b0;
			end_q       <= '0;
			rem_q       <= '0;
			save_dl_q   <= '0;
			save_pend_q <= 1'b0;
			phase_q     <= PH_IDLE;
			treat_q     <= 1'b0;
		end else if (advance) begin
			now_q       <= n_now;
			mode_q      <= n_mode;
			temp_q      <= n_temp;
			press_q     <= n_press;
			slot0_q     <= n_slot0;
			slot1_q     <= n_slot1;
			cycles_q    <= n_cycles;
			req_run_q   <= n_run;
			req_pause_q <= n_pause;
			req_left_q  <= n_left;
			req_right_q <= n_right;
			active_q    <= n_active;
			paused_q    <= n_paused;
			timer_q     <= n_timer;
			end_q       <= n_end;
			rem_q       <= n_rem;
			save_dl_q   <= n_save_dl;
			save_pend_q <= n_save_pend;
			phase_q     <= n_phase;
			treat_q     <= n_treat;
		end
	end

	// ---------------------------------------------------------------- result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign res_valid         = res_valid_s2;
	assign ctrl_command      = res_s2.command;
	assign ctrl_running      = res_s2.running;
	assign ctrl_mode         = res_s2.mode;
	assign ctrl_temperature  = res_s2.temperature;
	assign ctrl_pressure     = res_s2.pressure;
	assign ctrl_enables      = res_s2.enables;
	assign ctrl_cycles       = res_s2.cycles;
	assign save_request      = res_s2.save;
	assign broadcast_request = res_s2.broadcast;
	assign session_done      = res_s2.done;
	assign app_status        = res_s2.phase;
	assign treatment_on      = res_s2.treating;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		evt_stall |-> (evt_valid_s1 && res_valid_s2 && res_stall))
		else $error("event stalled while result path free");

	a_paused_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		paused_q |-> active_q)
		else $error("control paused without being active");

	a_cycles_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cycles_q != '0)
		else $error("session cycle count reached zero");

	a_tick_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (op_s1 == OP_TICK)) |=> (now_q == $past(now_q) + 32'd1))
		else $error("tick did not advance time");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking bench for session_run_pause_controller_top: random and directed event
// requests, an event-level model of the controller and an in-order result check.
// Depends on srpc_pkg and the controller RTL only.

module tb_top;
	import srpc_pkg::*;

	// Operation codes that the block leaves unused
	localparam logic [3:0] OP_SPARE_LO = 4'd14;
	localparam logic [3:0] OP_SPARE_HI = 4'd15;

	// Cycles without any handshake before the run is abandoned
	localparam int unsigned STALL_LIMIT = 1000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic        evt_valid = 1'b0;
	logic [3:0]  operation = '0;
	logic [15:0] value     = '0;
	logic        res_stall = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr  = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;

	wire logic        evt_stall;
	wire logic        res_valid;
	wire logic [2:0]  ctrl_command;
	wire logic        ctrl_running;
	wire logic [2:0]  ctrl_mode;
	wire logic [9:0]  ctrl_temperature;
	wire logic [9:0]  ctrl_pressure;
	wire logic [1:0]  ctrl_enables;
	wire logic [15:0] ctrl_cycles;
	wire logic        save_request;
	wire logic        broadcast_request;
	wire logic        session_done;
	wire logic [1:0]  app_status;
	wire logic        treatment_on;
	wire logic [CFG_DATA_W-1:0] prdata;
	wire logic        pready;

	session_run_pause_controller_top u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.evt_valid         (evt_valid),
		.evt_stall         (evt_stall),
		.operation         (operation),
		.value             (value),
		.res_valid         (res_valid),
		.res_stall         (res_stall),
		.ctrl_command      (ctrl_command),
		.ctrl_running      (ctrl_running),
		.ctrl_mode         (ctrl_mode),
		.ctrl_temperature  (ctrl_temperature),
		.ctrl_pressure     (ctrl_pressure),
		.ctrl_enables      (ctrl_enables),
		.ctrl_cycles       (ctrl_cycles),
		.save_request      (save_request),
		.broadcast_request (broadcast_request),
		.session_done      (session_done),
		.app_status        (app_status),
		.treatment_on      (treatment_on),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------
	// Controller model: register shadows and session state
	// ------------------------------------------------------------------
	logic [9:0]  comp_set, boot_temp_set, slot0_set, slot1_set;
	logic [7:0]  boot_mode_set;
	logic [15:0] cycle_ticks_set, save_delay_set;

	logic [31:0] tick_now, sess_deadline, sess_left, save_due;
	logic [2:0]  mode_sel;
	logic [9:0]  temp_goal, press_goal;
	logic [9:0]  slot_press [2];
	logic [15:0] cycle_count;
	logic        want_run, want_pause, want_left, want_right;
	logic        ctl_active, ctl_paused, ctl_timer;
	logic        save_armed, treating_now;
	phase_t      phase_now;
	result_t     rpt;

	// Control reports still owed by the block, oldest first
	result_t report_q [$];

	int unsigned fail_count = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned stall_burst = 0;
	int unsigned rx_cycle = 0;
	int unsigned quiet_cycles = 0;
	logic        calm = 1'b0;

	function automatic void reset_model();
		comp_set        = RST_TEMP_COMP;
		boot_mode_set   = RST_BOOT_MODE;
		boot_temp_set   = RST_BOOT_TEMP;
		slot0_set       = RST_SLOT_PRESS;
		slot1_set       = RST_SLOT_PRESS;
		cycle_ticks_set = RST_CYCLE_TICKS;
		save_delay_set  = RST_SAVE_DELAY;
		tick_now        = '0;
		mode_sel        = 3'd1;
		temp_goal       = '0;
		press_goal      = 10'(PRESSURE_DEFAULT);
		slot_press[0]   = 10'(PRESSURE_DEFAULT);
		slot_press[1]   = 10'(PRESSURE_DEFAULT);
		cycle_count     = 16'd1;
		{want_run, want_pause, want_left, want_right} = '0;
		{ctl_active, ctl_paused, ctl_timer} = '0;
		sess_deadline   = '0;
		sess_left       = '0;
		save_due        = '0;
		save_armed      = 1'b0;
		phase_now       = PH_IDLE;
		treating_now    = 1'b0;
	endfunction

	function automatic logic [9:0] sat_tenths(input logic [15:0] v);
		return (v > 16'(VALUE_MAX)) ? 10'(VALUE_MAX) : v[9:0];
	endfunction

	// A deadline counts as reached once the signed distance to it is not negative
	function automatic logic deadline_hit(input logic [31:0] mark);
		logic [31:0] diff;
		diff = tick_now - mark;
		return !diff[31];
	endfunction

	// Fill the command and settings part of the report
	function automatic void post(input cmd_t cmd, input logic running);
		rpt.command     = cmd;
		rpt.running     = running;
		rpt.mode        = mode_sel;
		rpt.temperature = (temp_goal > comp_set) ? temp_goal - comp_set : 10'd0;
		rpt.pressure    = press_goal;
		rpt.enables     = {want_right, want_left};
		rpt.cycles      = (cycle_count == 0) ? 16'd1 : cycle_count;
	endfunction

	function automatic void arm_session();
		logic [15:0] n;
		n = (cycle_count == 0) ? 16'd1 : cycle_count;
		sess_deadline = tick_now + 32'(cycle_ticks_set) * 32'(n);
		ctl_timer = 1'b1;
	endfunction

	function automatic void resume_session();
		if (sess_left != 0) begin
			sess_deadline = tick_now + sess_left;
			ctl_timer = 1'b1;
		end
	endfunction

	function automatic void freeze_session();
		if (ctl_timer && sess_deadline > tick_now) begin
			sess_left = sess_deadline - tick_now;
		end else begin
			sess_left = '0;
		end
		ctl_timer = 1'b0;
	endfunction

	function automatic void select_mode(input logic [15:0] m);
		logic [9:0] stored;
		if (m < 16'd1) m = 16'd1;
		if (m > 16'(MODE_MAX)) m = 16'(MODE_MAX);
		mode_sel = m[2:0];
		stored = slot_press[(m <= 16'd1) ? 0 : 1];
		press_goal = (stored != 0) ? stored : 10'(PRESSURE_DEFAULT);
	endfunction

	function automatic void schedule_save();
		save_due = tick_now + 32'(save_delay_set);
		save_armed = 1'b1;
	endfunction

	// Resolve run, pause and enable requests into the control command
	function automatic void settle_requests();
		if (want_run && (want_left || want_right)) begin
			if (want_pause) begin
				treating_now = 1'b0;
				phase_now = PH_READY;
				if (ctl_active && !ctl_paused) begin
					ctl_paused = 1'b1;
					post(CMD_PAUSE, 1'b1);
				end
			end else begin
				treating_now = 1'b1;
				phase_now = PH_RUN;
				if (!ctl_active) begin
					ctl_active = 1'b1;
					ctl_paused = 1'b0;
					post(CMD_START, 1'b1);
					if (!ctl_timer) begin
						if (sess_left != 0) resume_session();
						else arm_session();
					end
				end else if (ctl_paused) begin
					ctl_paused = 1'b0;
					post(CMD_RESUME, 1'b1);
					if (!ctl_timer) resume_session();
				end else begin
					post(CMD_UPDATE, 1'b1);
					if (!ctl_timer) arm_session();
				end
			end
		end else begin
			treating_now = 1'b0;
			if (ctl_active || ctl_paused) begin
				ctl_active = 1'b0;
				ctl_paused = 1'b0;
				post(CMD_STOP, 1'b0);
			end
			phase_now = PH_READY;
			ctl_timer = 1'b0;
			sess_left = '0;
		end
	endfunction

	// Apply one event to the model and return the report it causes
	function automatic result_t advance_controller(input logic [3:0] opc, input logic [15:0] val);
		rpt = '0;
		post(CMD_NONE, 1'b0);
		case (opc)
			OP_INIT: begin
				slot_press[0] = sat_tenths(16'(slot0_set));
				slot_press[1] = sat_tenths(16'(slot1_set));
				if (boot_mode_set >= 8'd1 && boot_mode_set <= 8'(MODE_MAX)) begin
					select_mode(16'(boot_mode_set));
				end else begin
					select_mode(16'd1);
				end
				temp_goal = sat_tenths(16'(boot_temp_set));
				{want_run, want_pause, want_left, want_right} = '0;
				{ctl_active, ctl_paused, ctl_timer} = '0;
				sess_left = '0;
				save_armed = 1'b0;
				save_due = '0;
				phase_now = PH_IDLE;
				post(CMD_NONE, 1'b0);
			end
			OP_TICK: begin
				tick_now = tick_now + 32'd1;
				if (save_armed && deadline_hit(save_due)) begin
					rpt.save = 1'b1;
					save_armed = 1'b0;
					save_due = '0;
				end
				if (ctl_active && !ctl_paused && ctl_timer && deadline_hit(sess_deadline)) begin
					want_run = 1'b0;
					want_pause = 1'b0;
					ctl_timer = 1'b0;
					sess_left = '0;
					settle_requests();
					rpt.done = 1'b1;
				end
			end
			OP_MODE: begin
				select_mode(val);
				settle_requests();
			end
			OP_TEMP: begin
				temp_goal = sat_tenths(val);
				schedule_save();
				settle_requests();
			end
			OP_PRESS: begin
				press_goal = sat_tenths(val);
				slot_press[(mode_sel <= 3'd1) ? 0 : 1] = press_goal;
				schedule_save();
				settle_requests();
			end
			OP_LEFT: begin
				want_left = (val != 0);
				settle_requests();
			end
			OP_RIGHT: begin
				want_right = (val != 0);
				settle_requests();
			end
			OP_CYCLES: begin
				cycle_count = (val == 0) ? 16'd1 : val;
				if (ctl_active) begin
					arm_session();
					settle_requests();
				end
			end
			OP_START: begin
				if (!want_left && !want_right) begin
					want_left = 1'b1;
					want_right = 1'b1;
				end
				want_pause = 1'b0;
				want_run = 1'b1;
				settle_requests();
			end
			OP_STOP: begin
				want_run = 1'b0;
				want_pause = 1'b0;
				settle_requests();
			end
			OP_PAUSE: begin
				if (val == 0) begin
					if (want_run && !want_pause) begin
						want_pause = 1'b1;
						freeze_session();
						settle_requests();
					end
				end else if (want_run && want_pause) begin
					want_pause = 1'b0;
					settle_requests();
				end
			end
			OP_READ: rpt.broadcast = 1'b1;
			OP_SAVE: rpt.save = 1'b1;
			OP_FAULT: begin
				if (val != 0) begin
					{want_run, want_pause, want_left, want_right} = '0;
					settle_requests();
					phase_now = PH_ALARM;
				end
			end
			default: ;
		endcase
		rpt.phase = phase_now;
		rpt.treating = treating_now;
		return rpt;
	endfunction

	// ------------------------------------------------------------------
	// Event sender, configuration writes and stimulus choices
	// ------------------------------------------------------------------

	// Offer one request, optionally after an idle burst, and hold it until taken
	task automatic send_event(input logic [3:0] opc, input logic [15:0] val);
		int unsigned gap;
		gap = 0;
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
			gap = $urandom_range(1, 15);
		if (gap != 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt_valid <= 1'b1;
		operation <= opc;
		value     <= val;
		do @(posedge clk); while (evt_stall);
		report_q.push_back(advance_controller(opc, val));
	endtask

	// Drop the request line and let every owed report drain out
	task automatic settle_block();
		evt_valid <= 1'b0;
		while (report_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One APB write: setup cycle then access cycle; psel is left for the caller
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_TEMP_COMP:   comp_set        = data[9:0];
			REG_BOOT_MODE:   boot_mode_set   = data[7:0];
			REG_BOOT_TEMP:   boot_temp_set   = data[9:0];
			REG_SLOT0_PRESS: slot0_set       = data[9:0];
			REG_SLOT1_PRESS: slot1_set       = data[9:0];
			REG_CYCLE_TICKS: cycle_ticks_set = data[15:0];
			REG_SAVE_DELAY:  save_delay_set  = data[15:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [9:0] comp, input logic [7:0] bmode,
			input logic [9:0] btemp, input logic [9:0] s0, input logic [9:0] s1,
			input logic [15:0] cyc, input logic [15:0] sdel);
		write_reg(REG_TEMP_COMP,   32'(comp));
		write_reg(REG_BOOT_MODE,   32'(bmode));
		write_reg(REG_BOOT_TEMP,   32'(btemp));
		write_reg(REG_SLOT0_PRESS, 32'(s0));
		write_reg(REG_SLOT1_PRESS, 32'(s1));
		write_reg(REG_CYCLE_TICKS, 32'(cyc));
		write_reg(REG_SAVE_DELAY,  32'(sdel));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	function automatic int unsigned pick_idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 35;
		endcase
	endfunction

	// Tick-heavy mix so that sessions run out and saves fall due
	function automatic logic [3:0] pick_operation();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 43) return OP_TICK;
		if (r < 50) return OP_START;
		if (r < 52) return OP_STOP;
		if (r < 61) return OP_PAUSE;
		if (r < 66) return OP_MODE;
		if (r < 72) return OP_TEMP;
		if (r < 78) return OP_PRESS;
		if (r < 83) return OP_LEFT;
		if (r < 88) return OP_RIGHT;
		if (r < 92) return OP_CYCLES;
		if (r < 94) return OP_READ;
		if (r < 96) return OP_SAVE;
		if (r < 98) return OP_FAULT;
		if (r < 99) return OP_INIT;
		return $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
	endfunction

	function automatic logic [15:0] pick_value(input logic [3:0] opc);
		int unsigned r;
		logic [15:0] v;
		r = $urandom_range(0, 99);
		v = 16'($urandom);
		case (opc)
			OP_MODE: if (r < 85) v = 16'($urandom_range(0, 6));
			OP_TEMP, OP_PRESS: begin
				if (r < 60) begin
					v = 16'($urandom_range(0, 1000));
				end else if (r < 80) begin
					case ($urandom_range(0, 3))
						0: v = 16'd0;
						1: v = 16'd1000;
						2: v = 16'd1001;
						default: v = 16'hFFFF;
					endcase
				end
			end
			OP_LEFT, OP_RIGHT: begin
				if (r < 25) v = 16'd0;
				else if (v == 0) v = 16'd1;
			end
			OP_PAUSE, OP_FAULT: if (r < 50) v = 16'd0;
			OP_CYCLES: begin
				if (r < 70) v = 16'($urandom_range(0, 3));
				else if (r < 90) v = 16'($urandom_range(1, 20));
			end
			default: ;
		endcase
		return v;
	endfunction

	task automatic drive_traffic(input int unsigned count);
		logic [3:0] opc;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 40 == 0) tx_idle_pct = calm ? 0 : pick_idle_pct();
			opc = pick_operation();
			send_event(opc, pick_value(opc));
		end
	endtask

	task automatic load_random_settings();
		logic [7:0]  bmode;
		logic [15:0] cyc, sdel;
		bmode = $urandom_range(0, 1) ? 8'($urandom_range(0, 5)) : 8'($urandom_range(0, 255));
		cyc   = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
			: 16'($urandom_range(1, 8));
		sdel  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
			: 16'($urandom_range(1, 30));
		load_settings(10'($urandom_range(0, 1000)), bmode, 10'($urandom_range(0, 1000)),
			10'($urandom_range(0, 1000)), 10'($urandom_range(0, 1000)), cyc, sdel);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset register values: long session and save delay, no boot load yet
	task automatic test_reset_defaults();
		send_event(OP_READ,  16'd0);
		send_event(OP_TEMP,  16'd500);
		send_event(OP_START, 16'd0);
		send_event(OP_TICK,  16'd0);
		send_event(OP_PAUSE, 16'd0);
		send_event(OP_STOP,  16'd0);
		send_event(OP_INIT,  16'd0);
		settle_block();
	endtask

	// Field extremes, every operation and the corner cases named in the spec
	task automatic test_directed();
		// boot mode outside 1..4, slot zero empty, two-tick cycles, save after one tick
		load_settings(10'd30, 8'd0, 10'd1000, 10'd0, 10'd1000, 16'd2, 16'd1);
		send_event(OP_INIT,     16'hFFFF);
		send_event(OP_MODE,     16'd0);      // clamps to mode 1, empty slot loads default
		send_event(OP_MODE,     16'hFFFF);   // clamps to mode 4, slot one
		send_event(OP_TEMP,     16'd20);     // below compensation: floored at zero
		send_event(OP_TEMP,     16'hFFFF);   // saturates
		send_event(OP_PRESS,    16'd1001);
		send_event(OP_PRESS,    16'd0);
		send_event(OP_TICK,     16'd0);      // pending save falls due
		send_event(OP_LEFT,     16'h8000);
		send_event(OP_RIGHT,    16'd0);
		send_event(OP_CYCLES,   16'd0);      // stored as one, control not active
		send_event(OP_START,    16'd0);
		send_event(OP_PAUSE,    16'd0);
		send_event(OP_TICK,     16'd0);      // countdown frozen
		send_event(OP_PAUSE,    16'h0001);   // resume with what was left
		send_event(OP_CYCLES,   16'hFFFF);   // rearms the countdown while active
		send_event(OP_CYCLES,   16'd1);
		send_event(OP_TICK,     16'd0);
		send_event(OP_TICK,     16'd0);      // session runs out
		send_event(OP_READ,     16'hFFFF);
		send_event(OP_SAVE,     16'h5555);
		send_event(OP_SPARE_LO, 16'hAAAA);
		send_event(OP_SPARE_HI, 16'hFFFF);
		send_event(OP_START,    16'd0);
		send_event(OP_FAULT,    16'd0);      // zero code is ignored
		send_event(OP_FAULT,    16'h8000);   // alarm and stop
		send_event(OP_STOP,     16'd0);
		settle_block();
	endtask

	task automatic test_random_settings();
		for (int p = 0; p < 5; p++) begin
			load_random_settings();
			send_event(OP_INIT, 16'($urandom));
			drive_traffic(230);
			settle_block();
		end
	endtask

	task automatic test_register_extremes();
		load_settings(10'd0, 8'd0, 10'd0, 10'd0, 10'd0, 16'd1, 16'd1);
		send_event(OP_INIT, 16'd0);
		drive_traffic(150);
		settle_block();
		load_settings(10'(VALUE_MAX), 8'hFF, 10'(VALUE_MAX), 10'(VALUE_MAX),
			10'(VALUE_MAX), 16'hFFFF, 16'hFFFF);
		send_event(OP_INIT, 16'hFFFF);
		drive_traffic(150);
		settle_block();
	endtask

	// Closing stretch at full rate on both sides
	task automatic test_no_idle();
		calm = 1'b1;
		load_random_settings();
		send_event(OP_INIT, 16'($urandom));
		drive_traffic(250);
		settle_block();
	endtask

	// ------------------------------------------------------------------
	// Result side: stall bursts, checking and watchdog
	// ------------------------------------------------------------------

	// Stall the result side in bursts; re-pick the stall density now and then
	always @(posedge clk) begin
		rx_cycle = rx_cycle + 1;
		if (calm) rx_idle_pct = 0;
		else if (rx_cycle % 64 == 0) rx_idle_pct = pick_idle_pct();
		if (stall_burst != 0) begin
			stall_burst = stall_burst - 1;
		end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
			stall_burst = $urandom_range(1, 15);
		end
		res_stall <= (stall_burst != 0);
	end

	function automatic void check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void rpt_check(input result_t want);
		check_field("ctrl_command",      16'(want.command),     16'(ctrl_command));
		check_field("ctrl_running",      16'(want.running),     16'(ctrl_running));
		check_field("ctrl_mode",         16'(want.mode),        16'(ctrl_mode));
		check_field("ctrl_temperature",  16'(want.temperature), 16'(ctrl_temperature));
		check_field("ctrl_pressure",     16'(want.pressure),    16'(ctrl_pressure));
		check_field("ctrl_enables",      16'(want.enables),     16'(ctrl_enables));
		check_field("ctrl_cycles",       want.cycles,           ctrl_cycles);
		check_field("save_request",      16'(want.save),        16'(save_request));
		check_field("broadcast_request", 16'(want.broadcast),   16'(broadcast_request));
		check_field("session_done",      16'(want.done),        16'(session_done));
		check_field("app_status",        16'(want.phase),       16'(app_status));
		check_field("treatment_on",      16'(want.treating),    16'(treatment_on));
	endfunction

	// Compare every accepted result with the oldest owed report
	always @(posedge clk) begin
		if (res_valid && !res_stall) begin
			if (report_q.size() == 0) begin
				$error("result accepted with no request outstanding");
				fail_count++;
			end else begin
				rpt_check(report_q.pop_front());
			end
		end
	end

	// Abandon the run if neither channel moves for too long
	always @(posedge clk) begin
		if ((evt_valid && !evt_stall) || (res_valid && !res_stall) || psel) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	// Hold reset, run the tests in turn, then report
	initial begin
		reset_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_directed();
		test_random_settings();
		test_register_extremes();
		test_no_idle();
		settle_block();
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

FILE: session_run_pause_controller_top.f
hdl/srpc_pkg.sv
hdl/session_run_pause_controller_top.sv
dv/tb_top.sv
